FILE: rtl/amm_pkg.sv
package amm_pkg;

	localparam int SampleW = 16;
	localparam int SlopeW = 31;
	localparam int ScaleW = 15;
	localparam int PhaseW = 3;
	localparam int ModeW = 4;

	localparam logic [SlopeW-1:0] SlopeOne = 31'd65536;

	localparam logic [ModeW-1:0] MODE_TEACH_CENTER = 4'd0;
	localparam logic [ModeW-1:0] MODE_TEACH_GLOBAL = 4'd1;
	localparam logic [ModeW-1:0] MODE_TEACH_BAL = 4'd2;
	localparam logic [ModeW-1:0] MODE_ADJ_GLOBAL = 4'd3;
	localparam logic [ModeW-1:0] MODE_ADJ_BAL = 4'd4;
	localparam logic [ModeW-1:0] MODE_ADJ_CLAMP = 4'd5;
	localparam logic [ModeW-1:0] MODE_CENTER_DONE = 4'd6;
	localparam logic [ModeW-1:0] MODE_EXTREMA_DONE = 4'd7;
	localparam logic [ModeW-1:0] MODE_CLEAR = 4'd8;

	localparam logic [PhaseW-1:0] PH_NONE = 3'd0;
	localparam logic [PhaseW-1:0] PH_CLEARED = 3'd1;
	localparam logic [PhaseW-1:0] PH_CPOINT = 3'd2;
	localparam logic [PhaseW-1:0] PH_CFIELD = 3'd3;
	localparam logic [PhaseW-1:0] PH_EXTREMAS = 3'd4;
	localparam logic [PhaseW-1:0] PH_CALIB = 3'd5;

	localparam logic [1:0] CFG_MAX_SCALE = 2'd0;
	localparam logic [1:0] CFG_CLAMP_POS = 2'd1;
	localparam logic [1:0] CFG_CLAMP_NEG = 2'd2;

	typedef struct packed {
		logic update;
		logic div_start;
		logic div_sel_neg;
		logic finish;
	} amm_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic div_done;
	} amm_status_t;

endpackage

FILE: rtl/axis_min_max_calibrator.sv
// Adjust, event and clear transactions pass through S_FINISH and S_OUT before out_valid.
// Teach global and teach balanced also wait on the 32-step radix-2 slope divider, which
// runs once per slope (two for teach balanced) whenever that slope's span is positive.
// One transaction is in flight at a time; the next is accepted as the result is taken.
// Reset (arst_n, asynchronous, active low) restores all calibration and config state.
module axis_min_max_calibrator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         mode,
	input  logic signed [15:0] raw_sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] final_value,
	output logic [2:0]         calib_state,
	output logic               event_taken
);

	logic [14:0] max_scale_q;
	logic signed [15:0] clamp_pos_q, clamp_neg_q;
	amm_pkg::amm_cmd_t cmd;
	amm_pkg::amm_status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_scale_q <= 15'd32767;
			clamp_pos_q <= 16'sd32767;
			clamp_neg_q <= -16'sd32768;
		end else if (cfg_we) begin
			unique case (cfg_index)
				amm_pkg::CFG_MAX_SCALE: max_scale_q <= cfg_data[14:0];
				amm_pkg::CFG_CLAMP_POS: clamp_pos_q <= cfg_data;
				amm_pkg::CFG_CLAMP_NEG: clamp_neg_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	amm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd), .status(status)
	);

	amm_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status), .mode(mode),
		.raw_sample(raw_sample), .max_scale(max_scale_q), .clamp_pos(clamp_pos_q),
		.clamp_neg(clamp_neg_q), .final_value(final_value),
		.calib_state(calib_state), .event_taken(event_taken)
	);

endmodule

FILE: rtl/amm_divider.sv
module amm_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [16:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [31:0] quotient
);

	logic [31:0] quo_q;
	logic [17:0] rem_q;
	logic [16:0] div_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [17:0] trial;
	logic [18:0] diff;

	assign trial = {rem_q[16:0], quo_q[31]};
	assign diff = {1'b0, trial} - {2'b00, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!diff[18]) begin
				rem_q <= diff[17:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/amm_datapath.sv
module amm_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  amm_pkg::amm_cmd_t     cmd,
	output amm_pkg::amm_status_t  status,
	input  logic [3:0]            mode,
	input  logic signed [15:0]    raw_sample,
	input  logic [14:0]           max_scale,
	input  logic signed [15:0]    clamp_pos,
	input  logic signed [15:0]    clamp_neg,
	output logic signed [15:0]    final_value,
	output logic [2:0]            calib_state,
	output logic                  event_taken
);

	logic signed [15:0] cmax_q, cmin_q, cpoint_q, smax_q, smin_q, zoff_q, last_q;
	logic [30:0] spos_q, sneg_q;
	logic [2:0] phase_q;
	logic taken_q;
	logic [3:0] mode_q;
	logic signed [15:0] raw_q;

	logic signed [15:0] n_cmax, n_cmin, n_zoff;
	logic signed [16:0] span_d, pos_d, neg_d;
	logic signed [16:0] den;
	logic [31:0] numer;
	logic div_busy, div_done;
	logic [31:0] quo;
	logic [30:0] slope_res;

	logic signed [16:0] adj_diff;
	logic [30:0] adj_slope;
	logic [15:0] adj_mag;
	logic [46:0] prod;
	logic [15:0] ptr;
	logic signed [15:0] mres;
	logic bal_pos;

	always_comb begin
		n_zoff = 16'((17'(smax_q) + 17'(smin_q)) / 17'sd2);
		span_d = 17'(smax_q) - 17'(smin_q);
		pos_d = 17'(smax_q) - 17'(cpoint_q);
		neg_d = 17'(cpoint_q) - 17'(smin_q);
		n_cmax = (raw_sample > cmax_q) ? raw_sample : cmax_q;
		n_cmin = (raw_sample < cmin_q) ? raw_sample : cmin_q;
	end

	always_comb begin
		if (mode_q == amm_pkg::MODE_TEACH_GLOBAL) begin
			den = span_d;
			numer = {1'b0, max_scale, 16'd0};
		end else begin
			den = cmd.div_sel_neg ? neg_d : pos_d;
			numer = {2'b00, max_scale, 15'd0};
		end
	end

	amm_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start && den > 0),
		.dividend(numer), .divisor(den[16:0]), .busy(div_busy),
		.done(div_done), .quotient(quo)
	);

	assign slope_res = quo[30:0];
	assign status.div_busy = div_busy;
	assign status.div_done = div_done;

	always_comb begin
		bal_pos = raw_q > cpoint_q;
		if (mode_q == amm_pkg::MODE_TEACH_GLOBAL) begin
			adj_diff = 17'(raw_q) - 17'(n_zoff);
			adj_slope = spos_q;
		end else if (mode_q == amm_pkg::MODE_ADJ_GLOBAL) begin
			adj_diff = 17'(raw_q) - 17'(zoff_q);
			adj_slope = spos_q;
		end else begin
			adj_diff = 17'(raw_q) - 17'(cpoint_q);
			adj_slope = bal_pos ? spos_q : sneg_q;
		end
		adj_mag = adj_diff[16] ? 16'(-adj_diff) : adj_diff[15:0];
		prod = 47'(adj_mag) * 47'(adj_slope);
		ptr = prod[31:16];
		mres = adj_diff[16] ? -$signed(ptr) : $signed(ptr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmax_q <= -16'sd32768; cmin_q <= 16'sd32767; cpoint_q <= '0;
			smax_q <= -16'sd32768; smin_q <= 16'sd32767; zoff_q <= '0;
			spos_q <= amm_pkg::SlopeOne; sneg_q <= amm_pkg::SlopeOne;
			last_q <= '0; phase_q <= amm_pkg::PH_NONE; taken_q <= 1'b0;
			mode_q <= '0; raw_q <= '0;
		end else begin
			if (cmd.update) begin
				mode_q <= mode;
				raw_q <= raw_sample;
				taken_q <= 1'b0;
				unique case (mode)
					amm_pkg::MODE_TEACH_CENTER: begin
						cmax_q <= n_cmax;
						cmin_q <= n_cmin;
						cpoint_q <= n_cmax / 16'sd2 + n_cmin / 16'sd2;
						smax_q <= (n_cmax > smax_q) ? n_cmax : smax_q;
						smin_q <= (n_cmin < smin_q) ? n_cmin : smin_q;
					end
					amm_pkg::MODE_TEACH_GLOBAL, amm_pkg::MODE_TEACH_BAL: begin
						smax_q <= (raw_sample > smax_q) ? raw_sample : smax_q;
						smin_q <= (raw_sample < smin_q) ? raw_sample : smin_q;
					end
					amm_pkg::MODE_CENTER_DONE: begin
						if (phase_q == amm_pkg::PH_CFIELD) begin
							phase_q <= amm_pkg::PH_EXTREMAS; taken_q <= 1'b1;
						end
					end
					amm_pkg::MODE_EXTREMA_DONE: begin
						if (phase_q == amm_pkg::PH_EXTREMAS) begin
							phase_q <= amm_pkg::PH_CALIB; taken_q <= 1'b1;
						end
					end
					amm_pkg::MODE_CLEAR: begin
						cmax_q <= -16'sd32768; cmin_q <= 16'sd32767; cpoint_q <= '0;
						smax_q <= -16'sd32768; smin_q <= 16'sd32767; zoff_q <= '0;
						spos_q <= amm_pkg::SlopeOne; sneg_q <= amm_pkg::SlopeOne;
						last_q <= '0; phase_q <= amm_pkg::PH_CLEARED;
					end
					default: begin
					end
				endcase
			end
			if (cmd.div_start) begin
				if (den <= 0) begin
					if (cmd.div_sel_neg) sneg_q <= amm_pkg::SlopeOne;
					else spos_q <= amm_pkg::SlopeOne;
				end
			end
			if (div_done) begin
				if (cmd.div_sel_neg) sneg_q <= slope_res;
				else spos_q <= slope_res;
			end
			if (cmd.finish) begin
				unique case (mode_q)
					amm_pkg::MODE_TEACH_CENTER, amm_pkg::MODE_TEACH_GLOBAL: begin
						zoff_q <= n_zoff;
						if (mode_q == amm_pkg::MODE_TEACH_GLOBAL) last_q <= mres;
						if (phase_q == amm_pkg::PH_CLEARED) phase_q <= amm_pkg::PH_CPOINT;
						else if (phase_q == amm_pkg::PH_CPOINT) phase_q <= amm_pkg::PH_CFIELD;
					end
					amm_pkg::MODE_TEACH_BAL: begin
						last_q <= mres;
						if (phase_q == amm_pkg::PH_CPOINT || phase_q == amm_pkg::PH_CFIELD)
							phase_q <= amm_pkg::PH_EXTREMAS;
					end
					amm_pkg::MODE_ADJ_GLOBAL, amm_pkg::MODE_ADJ_BAL: last_q <= mres;
					amm_pkg::MODE_ADJ_CLAMP: begin
						if (bal_pos) last_q <= (mres < -16'sd1 || mres > clamp_pos) ? clamp_pos : mres;
						else last_q <= (mres > 16'sd1 || mres < clamp_neg) ? clamp_neg : mres;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign final_value = last_q;
	assign calib_state = phase_q;
	assign event_taken = taken_q;

endmodule

FILE: rtl/amm_ctrl.sv
module amm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [3:0]           mode,
	output logic                 out_valid,
	input  logic                 out_ready,
	output amm_pkg::amm_cmd_t    cmd,
	input  amm_pkg::amm_status_t status
);

	typedef enum logic [2:0] {
		S_IDLE, S_DIV_POS, S_WAIT_POS, S_DIV_NEG, S_WAIT_NEG, S_FINISH, S_OUT
	} state_t;

	state_t state_q;
	logic [3:0] mode_q;
	logic valid_q;
	logic accept;

	assign in_ready = (state_q == S_IDLE) && (!valid_q || out_ready);
	assign accept = in_valid && in_ready;
	assign out_valid = valid_q;

	always_comb begin
		cmd.update = accept;
		cmd.div_start = (state_q == S_DIV_POS) || (state_q == S_DIV_NEG);
		cmd.div_sel_neg = (state_q == S_DIV_NEG) || (state_q == S_WAIT_NEG);
		cmd.finish = (state_q == S_FINISH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (valid_q && out_ready) valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q <= mode;
						if (mode == amm_pkg::MODE_TEACH_GLOBAL || mode == amm_pkg::MODE_TEACH_BAL)
							state_q <= S_DIV_POS;
						else
							state_q <= S_FINISH;
					end
				end
				S_DIV_POS: state_q <= S_WAIT_POS;
				S_WAIT_POS: begin
					if (!status.div_busy) begin
						if (mode_q == amm_pkg::MODE_TEACH_BAL) state_q <= S_DIV_NEG;
						else state_q <= S_FINISH;
					end
				end
				S_DIV_NEG: state_q <= S_WAIT_NEG;
				S_WAIT_NEG: if (!status.div_busy) state_q <= S_FINISH;
				S_FINISH: state_q <= S_OUT;
				S_OUT: begin
					valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_div_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> $past(status.div_busy)) else $error("spurious divide done");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> state_q == S_IDLE) else $error("accept outside idle");
	a_out_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_q) |-> $past(state_q == S_OUT)) else $error("result without finish");

endmodule

FILE: tb/axis_min_max_calibrator_tb.sv
module axis_min_max_calibrator_tb;

	localparam int IdleLimit = 20000;
	localparam int RandItems = 2000;

	typedef struct {
		logic [amm_pkg::ModeW-1:0] md;
		logic signed [15:0] raw;
		logic chk;
		logic signed [15:0] fv;
		logic [amm_pkg::PhaseW-1:0] ph;
		logic tk;
	} stim_row_t;

	typedef struct {
		logic signed [15:0] fv;
		logic [amm_pkg::PhaseW-1:0] ph;
		logic tk;
	} calib_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = amm_pkg::CFG_MAX_SCALE;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [3:0] mode = amm_pkg::MODE_TEACH_CENTER;
	logic signed [15:0] raw_sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] final_value;
	logic [2:0] calib_state;
	logic event_taken;

	axis_min_max_calibrator dut (.*);

	always #6 clk = ~clk;

	// Shadow copy of the calibration state.
	int unsigned m_scale;
	int m_cpos, m_cneg;
	int m_cmax, m_cmin, m_cpt, m_smax, m_smin, m_zoff, m_last;
	longint unsigned m_spos, m_sneg;
	int unsigned m_phase;

	calib_result_t expected_q[$];
	int errors = 0;
	int idle_cycles = 0;
	int accepted_in = 0;
	int taken_out = 0;
	int events_seen = 0;
	int clamps_hit = 0;
	bit no_idle = 0;
	bit hold_off = 0;

	function automatic void clear_calib();
		m_cmax = -32768; m_cmin = 32767; m_cpt = 0;
		m_smax = -32768; m_smin = 32767; m_zoff = 0;
		m_spos = 65536; m_sneg = 65536; m_last = 0;
	endfunction

	function automatic int scale_wrap(int diff, longint unsigned slope);
		longint unsigned mag, p;
		logic [15:0] r;
		mag = (diff < 0) ? -diff : diff;
		p = (mag * slope) >> 16;
		r = p[15:0];
		if (diff < 0) r = -r;
		return $signed(r);
	endfunction

	function automatic longint unsigned slope_for(longint unsigned num, int den);
		if (den <= 0) return 65536;
		return num / den;
	endfunction

	function automatic int halve(int v);
		return v / 2;
	endfunction

	function automatic void balanced_scale(int raw, bit clamped);
		if (raw > m_cpt) begin
			m_last = scale_wrap(raw - m_cpt, m_spos);
			if (clamped && (m_last < -1 || m_last > m_cpos)) begin
				m_last = m_cpos;
				clamps_hit++;
			end
		end else begin
			m_last = scale_wrap(raw - m_cpt, m_sneg);
			if (clamped && (m_last > 1 || m_last < m_cneg)) begin
				m_last = m_cneg;
				clamps_hit++;
			end
		end
	endfunction

	function automatic calib_result_t predict_calib(logic [amm_pkg::ModeW-1:0] md, int raw);
		calib_result_t r;
		bit tk;
		tk = 0;
		case (md)
			amm_pkg::MODE_TEACH_CENTER: begin
				if (raw > m_cmax) m_cmax = raw;
				if (raw < m_cmin) m_cmin = raw;
				m_cpt = halve(m_cmax) + halve(m_cmin);
				if (m_cmax > m_smax) m_smax = m_cmax;
				if (m_cmin < m_smin) m_smin = m_cmin;
				m_zoff = halve(m_smax + m_smin);
				if (m_phase == amm_pkg::PH_CLEARED) m_phase = amm_pkg::PH_CPOINT;
				else if (m_phase == amm_pkg::PH_CPOINT) m_phase = amm_pkg::PH_CFIELD;
			end
			amm_pkg::MODE_TEACH_GLOBAL: begin
				if (raw > m_smax) m_smax = raw;
				if (raw < m_smin) m_smin = raw;
				m_spos = slope_for(longint'(m_scale) * 65536, m_smax - m_smin);
				m_zoff = halve(m_smax + m_smin);
				m_last = scale_wrap(raw - m_zoff, m_spos);
				if (m_phase == amm_pkg::PH_CLEARED) m_phase = amm_pkg::PH_CPOINT;
				else if (m_phase == amm_pkg::PH_CPOINT) m_phase = amm_pkg::PH_CFIELD;
			end
			amm_pkg::MODE_TEACH_BAL: begin
				if (raw > m_smax) m_smax = raw;
				if (raw < m_smin) m_smin = raw;
				m_spos = slope_for(longint'(m_scale) * 32768, m_smax - m_cpt);
				m_sneg = slope_for(longint'(m_scale) * 32768, m_cpt - m_smin);
				balanced_scale(raw, 0);
				if (m_phase == amm_pkg::PH_CPOINT || m_phase == amm_pkg::PH_CFIELD)
					m_phase = amm_pkg::PH_EXTREMAS;
			end
			amm_pkg::MODE_ADJ_GLOBAL: m_last = scale_wrap(raw - m_zoff, m_spos);
			amm_pkg::MODE_ADJ_BAL: balanced_scale(raw, 0);
			amm_pkg::MODE_ADJ_CLAMP: balanced_scale(raw, 1);
			amm_pkg::MODE_CENTER_DONE: if (m_phase == amm_pkg::PH_CFIELD) begin
				m_phase = amm_pkg::PH_EXTREMAS;
				tk = 1;
			end
			amm_pkg::MODE_EXTREMA_DONE: if (m_phase == amm_pkg::PH_EXTREMAS) begin
				m_phase = amm_pkg::PH_CALIB;
				tk = 1;
			end
			amm_pkg::MODE_CLEAR: begin
				clear_calib();
				m_phase = amm_pkg::PH_CLEARED;
			end
			default: ;
		endcase
		r.fv = m_last[15:0];
		r.ph = m_phase[2:0];
		r.tk = tk;
		return r;
	endfunction

	// Directed rows; chk marks a typed-in expectation checked against the predictor.
	stim_row_t rows[$] = '{
		'{amm_pkg::MODE_ADJ_GLOBAL, 16'sd100, 1, 16'sd100, amm_pkg::PH_NONE, 0},
		'{amm_pkg::MODE_CENTER_DONE, 16'sd0, 1, 16'sd100, amm_pkg::PH_NONE, 0},
		'{4'd12, -16'sd1, 1, 16'sd100, amm_pkg::PH_NONE, 0},
		'{4'd15, 16'sd0, 1, 16'sd100, amm_pkg::PH_NONE, 0},
		'{amm_pkg::MODE_CLEAR, 16'sd0, 1, 16'sd0, amm_pkg::PH_CLEARED, 0},
		'{amm_pkg::MODE_TEACH_CENTER, 16'sd40, 0, 0, 0, 0},
		'{amm_pkg::MODE_TEACH_CENTER, -16'sd30, 0, 0, 0, 0},
		'{amm_pkg::MODE_EXTREMA_DONE, 16'sd0, 1, 16'sd0, amm_pkg::PH_CFIELD, 0},
		'{amm_pkg::MODE_CENTER_DONE, 16'sd0, 1, 16'sd0, amm_pkg::PH_EXTREMAS, 1},
		'{amm_pkg::MODE_TEACH_BAL, 16'sd32767, 0, 0, 0, 0},
		'{amm_pkg::MODE_TEACH_BAL, -16'sd32768, 0, 0, 0, 0},
		'{amm_pkg::MODE_ADJ_BAL, 16'sd20000, 0, 0, 0, 0},
		'{amm_pkg::MODE_ADJ_CLAMP, 16'sd32767, 0, 0, 0, 0},
		'{amm_pkg::MODE_ADJ_CLAMP, -16'sd32768, 0, 0, 0, 0},
		'{amm_pkg::MODE_EXTREMA_DONE, 16'sd0, 0, 0, 0, 0},
		'{amm_pkg::MODE_ADJ_GLOBAL, -16'sd32768, 0, 0, 0, 0},
		'{amm_pkg::MODE_CLEAR, 16'sd0, 1, 16'sd0, amm_pkg::PH_CLEARED, 0},
		'{amm_pkg::MODE_TEACH_GLOBAL, 16'sd5, 0, 0, 0, 0},
		'{amm_pkg::MODE_TEACH_GLOBAL, 16'sd5, 0, 0, 0, 0},
		'{amm_pkg::MODE_TEACH_GLOBAL, -16'sd32768, 0, 0, 0, 0},
		'{amm_pkg::MODE_TEACH_GLOBAL, 16'sd32767, 0, 0, 0, 0},
		'{amm_pkg::MODE_ADJ_GLOBAL, 16'sd32767, 0, 0, 0, 0},
		'{amm_pkg::MODE_TEACH_BAL, 16'sd0, 0, 0, 0, 0},
		'{amm_pkg::MODE_ADJ_CLAMP, 16'sd1, 0, 0, 0, 0}
	};

	task automatic send_item(logic [amm_pkg::ModeW-1:0] md, logic signed [15:0] raw);
		while (!no_idle && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= md;
		raw_sample <= raw;
		do @(posedge clk); while (!in_ready);
		accepted_in++;
		expected_q.push_back(predict_calib(md, raw));
		@(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		in_valid <= 1'b0;
		wait (expected_q.size() == 0);
		repeat (80) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			amm_pkg::CFG_MAX_SCALE: m_scale = val[14:0];
			amm_pkg::CFG_CLAMP_POS: m_cpos = $signed(val);
			default: m_cneg = $signed(val);
		endcase
	endtask

	function automatic logic signed [15:0] rand_raw();
		case ($urandom_range(7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return $signed(16'($urandom_range(64))) - 16'sd32;
			default: return $signed(16'($urandom()));
		endcase
	endfunction

	task automatic run_random(int n);
		int i, k;
		for (i = 0; i < n; i += k) begin
			// Mostly a full calibration sequence, with noise mixed in.
			k = 0;
			if ($urandom_range(9) < 7) begin
				send_item(amm_pkg::MODE_CLEAR, rand_raw()); k++;
				repeat ($urandom_range(5, 1)) begin
					send_item(amm_pkg::MODE_TEACH_CENTER, rand_raw()); k++;
				end
				if ($urandom_range(1)) begin
					repeat ($urandom_range(4, 1)) begin
						send_item(amm_pkg::MODE_TEACH_GLOBAL, rand_raw()); k++;
					end
				end
				send_item(amm_pkg::MODE_CENTER_DONE, rand_raw()); k++;
				repeat ($urandom_range(4, 1)) begin
					send_item(amm_pkg::MODE_TEACH_BAL, rand_raw()); k++;
				end
				send_item(amm_pkg::MODE_EXTREMA_DONE, rand_raw()); k++;
				repeat ($urandom_range(12, 3)) begin
					send_item(4'(3 + $urandom_range(2)), rand_raw()); k++;
				end
			end else begin
				repeat (8) begin
					send_item(4'($urandom_range(15)), rand_raw()); k++;
				end
			end
		end
	endtask

	initial begin
		m_scale = 32767; m_cpos = 32767; m_cneg = -32768;
		clear_calib();
		m_phase = amm_pkg::PH_NONE;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (rows[r]) begin
			send_item(rows[r].md, rows[r].raw);
			if (rows[r].chk && (expected_q[$].fv !== rows[r].fv ||
					expected_q[$].ph !== rows[r].ph || expected_q[$].tk !== rows[r].tk)) begin
				$error("table row %0d disagrees with predictor", r);
				errors++;
			end
		end
		write_reg(amm_pkg::CFG_MAX_SCALE, 16'd0);
		write_reg(amm_pkg::CFG_CLAMP_POS, 16'sd0);
		write_reg(amm_pkg::CFG_CLAMP_NEG, 16'sd0);
		run_random(300);
		write_reg(amm_pkg::CFG_MAX_SCALE, 16'd1);
		write_reg(amm_pkg::CFG_CLAMP_POS, -16'sd32768);
		write_reg(amm_pkg::CFG_CLAMP_NEG, 16'sd32767);
		run_random(300);
		write_reg(amm_pkg::CFG_MAX_SCALE, 16'($urandom_range(32767)));
		write_reg(amm_pkg::CFG_CLAMP_POS, 16'($urandom_range(32767)));
		write_reg(amm_pkg::CFG_CLAMP_NEG, -16'($urandom_range(32768)));
		no_idle = 1;
		run_random(300);
		no_idle = 0;
		write_reg(amm_pkg::CFG_MAX_SCALE, 16'hffff);
		write_reg(amm_pkg::CFG_CLAMP_POS, 16'sd32767);
		write_reg(amm_pkg::CFG_CLAMP_NEG, -16'sd32768);
		run_random(RandItems - 900);
		in_valid <= 1'b0;
		wait (expected_q.size() == 0);
		repeat (100) @(posedge clk);
		$display("Ran %0d transactions, %0d results, %0d state events, %0d clamps.",
			accepted_in, taken_out, events_seen, clamps_hit);
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

	// Receiver: random stalls plus one long hold-off.
	initial begin
		int c;
		c = 0;
		forever begin
			@(negedge clk);
			c++;
			if (c == 3000) hold_off = 1;
			if (c == 3400) hold_off = 0;
			out_ready <= !hold_off && (no_idle || $urandom_range(99) >= 7);
		end
	end

	always @(posedge clk) begin
		calib_result_t e;
		if (arst_n && (in_valid && in_ready || out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IdleLimit) begin
			$display("FAIL");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			taken_out++;
			if (expected_q.size() == 0) begin
				$error("result with no expectation pending");
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (e.tk) events_seen++;
				if (final_value !== e.fv) begin
					$error("final_value exp %0d got %0d", e.fv, final_value);
					errors++;
				end
				if (calib_state !== e.ph) begin
					$error("calib_state exp %0d got %0d", e.ph, calib_state);
					errors++;
				end
				if (event_taken !== e.tk) begin
					$error("event_taken exp %0d got %0d", e.tk, event_taken);
					errors++;
				end
			end
		end
	end

endmodule
